// ----- src/crc8bfr_pkg.sv -----
package crc8bfr_pkg;

   // frame geometry
   localparam int FRAME_LEN  = 5;
   localparam int BYTE_IDX_W = $clog2(FRAME_LEN);
   localparam int BYTE_CNT_W = $clog2(FRAME_LEN + 1);

   // frame and crc constants
   localparam logic [7:0] HDR_BYTE = 8'h5A;
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // lost-link counter
   localparam logic [6:0] LINK_PARK = 7'd100;
   localparam logic [6:0] LINK_MAX  = 7'd127;

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DISCONNECT = CSR_IDX_W'(1);
   localparam logic [7:0] TIMEOUT_RST    = 8'd3;
   localparam logic [6:0] DISCONNECT_RST = 7'd60;

   typedef enum logic [1:0] {
      FRAME_NONE = 2'd0,
      FRAME_OK   = 2'd1,
      FRAME_BAD  = 2'd2
   } frame_res_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0] frame_result;
      logic       battery_lithium;
      logic       charging;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CRC,
      ST_APPLY,
      ST_LINK,
      ST_FINISH
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic take_byte;
      logic take_tick;
      logic crc_step;
      logic apply_check;
      logic link_step;
      logic load_rsp;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic check_due;
      logic crc_last;
      logic rsp_free;
   } dp_sts_type;

   // one byte through the msb-first crc-8 shift register
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- src/crc8_battery_frame_receiver_unit.sv -----
// sequence: a byte word goes straight to the result hand-off; a tick that checks
//   nothing passes the lost-link update first; a tick that checks the frame walks the
//   crc over every buffered byte but the last, one per cycle, then applies the check
//   and the lost-link update; the hand-off waits while the output register is full
// flow: one word at a time, the next word taken the cycle after the result is loaded into the output register
// reset: synchronous, clears buffer, counters and flags, timeout 3, disconnect limit 60
module crc8_battery_frame_receiver_unit
   import crc8bfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input words: a uart byte or a 10 ms tick
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   // result words: check outcome and battery state
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word,
   // register writes, always taken
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   // sequencer: accept, crc walk, apply check, lost-link update, hand off
   crc8bfr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_tick (req_word.req_type),
      .req_ready   (req_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   // frame buffer, timers, flags, crc register and output register
   crc8bfr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- src/crc8bfr_ctrl.sv -----
module crc8bfr_ctrl
   import crc8bfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_is_tick,
   output logic          req_ready,
   input  dp_sts_type    sts,
   output dp_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_is_tick) begin
                  cmd.take_tick = 1'b1;
                  state_in      = sts.check_due ? ST_CRC : ST_LINK;
               end else begin
                  cmd.take_byte = 1'b1;
                  state_in      = ST_FINISH;
               end
            end
         end
         ST_CRC: begin
            cmd.crc_step = 1'b1;
            if (sts.crc_last) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply_check = 1'b1;
            state_in        = ST_LINK;
         end
         ST_LINK: begin
            cmd.link_step = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/crc8bfr_datapath.sv -----
module crc8bfr_datapath
   import crc8bfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_word_type          req_word,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word
);

   logic [7:0]            timeout_ff, timeout_in;
   logic [6:0]            disc_limit_ff, disc_limit_in;
   logic [7:0]            buf_ff [FRAME_LEN];
   logic [7:0]            buf_in [FRAME_LEN];
   logic [BYTE_CNT_W-1:0] count_ff, count_in;
   logic                  full_ff, full_in;
   logic [7:0]            silence_ff, silence_in;
   logic [6:0]            link_ff, link_in;
   logic                  lith_ff, lith_in;
   logic                  chg_ff, chg_in;
   logic [7:0]            crc_ff, crc_in;
   logic [BYTE_IDX_W-1:0] crc_idx_ff, crc_idx_in;
   frame_res_type         res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic [7:0]            first_byte;
   logic [BYTE_CNT_W-1:0] count_next;
   logic                  frame_ok;
   logic [6:0]            link_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RST;
         disc_limit_ff <= DISCONNECT_RST;
         for (int i = 0; i < FRAME_LEN; i++) begin
            buf_ff[i] <= '0;
         end
         count_ff      <= '0;
         full_ff       <= 1'b0;
         silence_ff    <= '0;
         link_ff       <= '0;
         lith_ff       <= 1'b0;
         chg_ff        <= 1'b0;
         res_ff        <= FRAME_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         timeout_ff    <= timeout_in;
         disc_limit_ff <= disc_limit_in;
         buf_ff        <= buf_in;
         count_ff      <= count_in;
         full_ff       <= full_in;
         silence_ff    <= silence_in;
         link_ff       <= link_in;
         lith_ff       <= lith_in;
         chg_ff        <= chg_in;
         res_ff        <= res_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      crc_ff      <= crc_in;
      crc_idx_ff  <= crc_idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   // header seen after writing the byte
   assign first_byte = (count_ff == '0) ? req_word.rx_byte : buf_ff[0];
   assign count_next = (first_byte != HDR_BYTE) ? '0 : BYTE_CNT_W'(count_ff + 1'b1);

   assign frame_ok = (buf_ff[0] == HDR_BYTE) && (buf_ff[1] <= 8'd1)
                  && (crc_ff == buf_ff[FRAME_LEN-1]);

   assign link_inc = (link_ff < LINK_MAX) ? 7'(link_ff + 1'b1) : link_ff;

   always_comb begin
      timeout_in    = timeout_ff;
      disc_limit_in = disc_limit_ff;
      buf_in        = buf_ff;
      count_in      = count_ff;
      full_in       = full_ff;
      silence_in    = silence_ff;
      link_in       = link_ff;
      lith_in       = lith_ff;
      chg_in        = chg_ff;
      crc_in        = crc_ff;
      crc_idx_in    = crc_idx_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;

      if (csr_valid) begin
         if (csr_index == CSR_TIMEOUT) begin
            timeout_in = csr_data[7:0];
         end else if (csr_index == CSR_DISCONNECT) begin
            disc_limit_in = csr_data[6:0];
         end
      end

      if (cmd.take_byte) begin
         res_in = FRAME_NONE;
         if (!full_ff) begin
            silence_in = timeout_ff;
            if (count_ff < BYTE_CNT_W'(FRAME_LEN)) begin
               buf_in[count_ff[BYTE_IDX_W-1:0]] = req_word.rx_byte;
               count_in = count_next;
               full_in  = (count_next >= BYTE_CNT_W'(FRAME_LEN));
            end else begin
               count_in = '0;
               full_in  = 1'b1;
            end
         end
      end

      if (cmd.take_tick) begin
         res_in     = FRAME_NONE;
         crc_in     = CRC_INIT;
         crc_idx_in = '0;
         if (full_ff) begin
            silence_in = '0;
         end else if (silence_ff != '0) begin
            silence_in = 8'(silence_ff - 1'b1);
         end
      end

      if (cmd.crc_step) begin
         crc_in     = crc8_update(crc_ff, buf_ff[crc_idx_ff]);
         crc_idx_in = BYTE_IDX_W'(crc_idx_ff + 1'b1);
      end

      if (cmd.apply_check) begin
         if (frame_ok) begin
            res_in  = FRAME_OK;
            link_in = '0;
            if (buf_ff[1] == '0 && buf_ff[2] == '0 && buf_ff[3] == '0) begin
               lith_in = 1'b0;
            end else begin
               lith_in = 1'b1;
               chg_in  = (buf_ff[1] != '0);
            end
         end else begin
            res_in = FRAME_BAD;
         end
         for (int i = 0; i < FRAME_LEN; i++) begin
            buf_in[i] = '0;
         end
         count_in = '0;
         full_in  = 1'b0;
      end

      if (cmd.link_step) begin
         if (link_inc > disc_limit_ff) begin
            link_in = LINK_PARK;
            lith_in = 1'b0;
         end else begin
            link_in = link_inc;
         end
      end

      // output register: a load wins over a retire in the same cycle
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in                = 1'b1;
         rsp_word_in.frame_result    = res_ff;
         rsp_word_in.battery_lithium = lith_ff;
         rsp_word_in.charging        = chg_ff;
      end
   end

   assign sts.check_due = full_ff || (silence_ff == 8'd1);
   assign sts.crc_last  = (crc_idx_ff == BYTE_IDX_W'(FRAME_LEN - 2));
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- src/crc8bfr_checker.sv -----
module crc8bfr_checker
   import crc8bfr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word dropped or changed under stall");

   // only the three defined outcomes are reported
   a_res_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.frame_result == FRAME_NONE)
                 || (rsp_word.frame_result == FRAME_OK)
                 || (rsp_word.frame_result == FRAME_BAD))
      else $error("undefined frame result code");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // one word in flight: no second word right behind an accepted one
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a word is in flight");

endmodule

bind crc8_battery_frame_receiver_unit crc8bfr_checker u_checker (.*);

// ----- verif/crc8_battery_frame_receiver_unit_tb.sv -----
module crc8_battery_frame_receiver_unit_tb;
   import crc8bfr_pkg::*;

   // word kinds on the input channel
   localparam logic TYPE_BYTE = 1'b0;
   localparam logic TYPE_TICK = 1'b1;

   // register indexes that decode to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = CSR_IDX_W'(3);

   // cycles to let pass once the last status word is back
   localparam int SETTLE_CYCLES = 12;
   localparam int TAIL_CYCLES   = 20;

   typedef logic [FRAME_LEN-1:0][7:0] frame_bytes_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // predicted receiver state and register copies
   frame_bytes_type       rx_buf;
   logic [BYTE_CNT_W-1:0] rx_count;
   logic                  rx_full;
   logic [7:0]            rx_silence;
   logic [6:0]            rx_link;
   logic                  rx_lithium;
   logic                  rx_charge;
   logic [7:0]            cfg_timeout;
   logic [6:0]            cfg_disconnect;

   // status words still owed by the block, oldest first
   rsp_word_type status_due[$];
   rsp_word_type want;

   int fail_count    = 0;
   int words_sent    = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;

   crc8_battery_frame_receiver_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // frame predictor
   // ---------------------------------------------------------------

   // msb-first crc-8 over every byte but the last
   function automatic logic [7:0] frame_crc8(input frame_bytes_type fb);
      logic [7:0] c;
      logic       msb;
      c = CRC_INIT;
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
         c = c ^ fb[i];
         repeat (8) begin
            msb = c[7];
            c = c << 1;
            if (msb) begin
               c = c ^ CRC_POLY;
            end
         end
      end
      return c;
   endfunction

   task automatic clear_receiver_state();
      cfg_timeout    = TIMEOUT_RST;
      cfg_disconnect = DISCONNECT_RST;
      rx_buf         = '0;
      rx_count       = '0;
      rx_full        = 1'b0;
      rx_silence     = '0;
      rx_link        = '0;
      rx_lithium     = 1'b0;
      rx_charge      = 1'b0;
   endtask

   // verdict on the buffered frame, then the buffer starts over
   task automatic judge_frame(output frame_res_type verdict);
      if (rx_buf[0] == HDR_BYTE && rx_buf[1] <= 8'd1 &&
          frame_crc8(rx_buf) == rx_buf[FRAME_LEN-1]) begin
         rx_link = '0;
         if (rx_buf[1] == 8'd0 && rx_buf[2] == 8'd0 && rx_buf[3] == 8'd0) begin
            // lead or adapter frame, charge flag is left alone
            rx_lithium = 1'b0;
         end else begin
            rx_lithium = 1'b1;
            rx_charge  = (rx_buf[1] != 8'd0);
         end
         verdict = FRAME_OK;
      end else begin
         verdict = FRAME_BAD;
      end
      rx_buf   = '0;
      rx_count = '0;
      rx_full  = 1'b0;
   endtask

   // next status word for one accepted input word
   task automatic advance_receiver(input req_word_type w, output rsp_word_type r,
                                   output bit ignored);
      frame_res_type verdict;
      verdict = FRAME_NONE;
      ignored = 1'b0;
      if (w.req_type == TYPE_BYTE) begin
         if (rx_full) begin
            // frame waiting for its check, byte is dropped and timer keeps running
            ignored = 1'b1;
         end else begin
            rx_silence = cfg_timeout;
            if (rx_count < FRAME_LEN) begin
               rx_buf[rx_count] = w.rx_byte;
               if (rx_buf[0] != HDR_BYTE) begin
                  rx_count = '0;
               end else begin
                  rx_count = rx_count + 1'b1;
               end
               if (rx_count >= FRAME_LEN) begin
                  rx_full = 1'b1;
               end
            end else begin
               rx_count = '0;
               rx_full  = 1'b1;
            end
         end
      end else begin
         if (rx_full) begin
            rx_silence = '0;
            judge_frame(verdict);
         end else if (rx_silence != 8'd0) begin
            rx_silence = rx_silence - 1'b1;
            if (rx_silence == 8'd0) begin
               judge_frame(verdict);
            end
         end
         if (rx_link < LINK_MAX) begin
            rx_link = rx_link + 1'b1;
         end
         if (rx_link > cfg_disconnect) begin
            rx_link    = LINK_PARK;
            rx_lithium = 1'b0;
         end
      end
      r.frame_result    = verdict;
      r.battery_lithium = rx_lithium;
      r.charging        = rx_charge;
   endtask

   // ---------------------------------------------------------------
   // channel drivers
   // ---------------------------------------------------------------

   // offer one word, optionally after an idle gap, and log what it should return
   task automatic send_word(input req_word_type w);
      rsp_word_type r;
      bit           ignored;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      advance_receiver(w, r, ignored);
      status_due.push_back(r);
      if (!ignored) begin
         words_sent++;
      end
   endtask

   task automatic send_byte(input logic [7:0] v);
      req_word_type w;
      w.req_type = TYPE_BYTE;
      w.rx_byte  = v;
      send_word(w);
   endtask

   // the byte lane carries junk on ticks
   task automatic send_tick();
      req_word_type w;
      w.req_type = TYPE_TICK;
      w.rx_byte  = 8'($urandom_range(255));
      send_word(w);
   endtask

   task automatic send_frame(input frame_bytes_type fb);
      for (int i = 0; i < FRAME_LEN; i++) begin
         send_byte(fb[i]);
      end
   endtask

   // stop offering, wait for every owed word and a little beyond
   task automatic settle_block();
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TIMEOUT:    cfg_timeout    = data;
         CSR_DISCONNECT: cfg_disconnect = data[6:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // a frame with header and random content, byte 1 mostly 0 or 1, crc right unless asked otherwise
   function automatic frame_bytes_type build_frame(input bit lead, input bit break_crc);
      frame_bytes_type fb;
      fb    = '0;
      fb[0] = HDR_BYTE;
      if (!lead) begin
         fb[1] = ($urandom_range(99) < 85) ? 8'($urandom_range(1)) : 8'($urandom_range(255));
         fb[2] = ($urandom_range(99) < 10) ? 8'd0 : 8'($urandom_range(255));
         fb[3] = ($urandom_range(99) < 10) ? 8'd0 : 8'($urandom_range(255));
      end
      fb[FRAME_LEN-1] = frame_crc8(fb);
      if (break_crc) begin
         fb[FRAME_LEN-1] = fb[FRAME_LEN-1] ^ (8'd1 << $urandom_range(7));
      end
      return fb;
   endfunction

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------

   // receiver readiness, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // each status word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("status word %h with nothing owed", rsp_word);
            end
         end else begin
            want = status_due.pop_front();
            if (rsp_word.frame_result !== want.frame_result ||
                rsp_word.battery_lithium !== want.battery_lithium ||
                rsp_word.charging !== want.charging) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display({"status mismatch: result exp %0d got %0d, ",
                            "lithium exp %0d got %0d, charging exp %0d got %0d"},
                           want.frame_result, rsp_word.frame_result,
                           want.battery_lithium, rsp_word.battery_lithium,
                           want.charging, rsp_word.charging);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // a lone tick straight out of reset checks nothing
   task automatic test_reset_defaults();
      send_tick();
   endtask

   task automatic test_frame_cases();
      frame_bytes_type fb;
      // lithium frame, charging, with a stray byte while full
      fb    = '0;
      fb[0] = HDR_BYTE;
      fb[1] = 8'd1;
      fb[2] = 8'hFF;
      fb[3] = 8'h00;
      fb[4] = frame_crc8(fb);
      send_frame(fb);
      send_byte(8'hFF);
      send_tick();
      // leading byte that is no header, then silence runs out on it
      send_byte(8'hFF);
      repeat (3) send_tick();
      // lead frame: bytes 1 to 3 zero
      fb    = '0;
      fb[0] = HDR_BYTE;
      fb[4] = frame_crc8(fb);
      send_frame(fb);
      send_tick();
      // byte1 out of range on a partial frame, unfilled bytes read as zero
      send_byte(HDR_BYTE);
      send_byte(8'd2);
      repeat (3) send_tick();
   endtask

   task automatic test_register_writes();
      frame_bytes_type fb;
      settle_block();
      // spare indexes must leave the timeout at its reset value
      write_reg(CSR_SPARE_A, 8'h00);
      write_reg(CSR_SPARE_B, 8'hFF);
      send_byte(HDR_BYTE);
      repeat (3) send_tick();
      // timeout of zero: partial frame sits until it fills
      settle_block();
      write_reg(CSR_TIMEOUT, 8'd0);
      fb    = '0;
      fb[0] = HDR_BYTE;
      fb[2] = 8'h01;
      fb[3] = 8'h02;
      fb[4] = frame_crc8(fb);
      send_byte(fb[0]);
      repeat (4) send_tick();
      for (int i = 1; i < FRAME_LEN; i++) begin
         send_byte(fb[i]);
      end
      send_tick();
      // disconnect data wider than the register is masked
      settle_block();
      write_reg(CSR_DISCONNECT, 8'hFF);
      repeat (2) send_tick();
   endtask

   task automatic load_setting(input int k);
      settle_block();
      case (k)
         0: begin write_reg(CSR_TIMEOUT, 8'd3);   write_reg(CSR_DISCONNECT, 8'd60);  end
         1: begin write_reg(CSR_TIMEOUT, 8'd1);   write_reg(CSR_DISCONNECT, 8'd1);   end
         2: begin write_reg(CSR_TIMEOUT, 8'd255); write_reg(CSR_DISCONNECT, 8'd99);  end
         3: begin write_reg(CSR_TIMEOUT, 8'd0);   write_reg(CSR_DISCONNECT, 8'hFF);  end
         4: begin write_reg(CSR_TIMEOUT, 8'd2);   write_reg(CSR_DISCONNECT, 8'd5);   end
         5: begin write_reg(CSR_TIMEOUT, 8'd6);   write_reg(CSR_DISCONNECT, 8'd0);   end
         6: begin write_reg(CSR_TIMEOUT, 8'd4);   write_reg(CSR_DISCONNECT, 8'd30);  end
         default: begin write_reg(CSR_TIMEOUT, 8'd5); write_reg(CSR_DISCONNECT, 8'h81); end
      endcase
   endtask

   // mostly whole frames, plus partial frames, tick runs and noise
   task automatic test_random_traffic(input int n_words);
      frame_bytes_type fb;
      int              first;
      int              kind;
      int              n;
      req_word_type    w;
      first = words_sent;
      while (words_sent - first < n_words) begin
         kind = $urandom_range(99);
         if (kind < 55) begin
            fb = build_frame($urandom_range(99) < 20, $urandom_range(99) < 12);
            for (int i = 0; i < FRAME_LEN; i++) begin
               send_byte(fb[i]);
               if ($urandom_range(99) < 8) begin
                  send_tick();
               end
            end
            if ($urandom_range(99) < 15) begin
               repeat ($urandom_range(2, 1)) send_byte(8'($urandom_range(255)));
            end
            repeat ($urandom_range(2, 1)) send_tick();
         end else if (kind < 75) begin
            send_byte(HDR_BYTE);
            repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
            if (cfg_timeout >= 8'd1 && cfg_timeout <= 8'd8) begin
               n = cfg_timeout;
            end else begin
               n = $urandom_range(5, 1);
            end
            repeat (n) send_tick();
         end else if (kind < 90) begin
            repeat ($urandom_range(25, 1)) send_tick();
         end else begin
            repeat ($urandom_range(6, 1)) begin
               w.req_type = 1'($urandom_range(1));
               w.rx_byte  = 8'($urandom_range(255));
               send_word(w);
            end
         end
      end
   endtask

   // receiver holds off while frames keep coming, so the input backs up
   task automatic test_output_backpressure();
      settle_block();
      write_reg(CSR_TIMEOUT, 8'd3);
      write_reg(CSR_DISCONNECT, 8'd60);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 400;
      test_random_traffic(40);
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------

   initial begin
      clear_receiver_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_frame_cases();
      test_register_writes();

      // idling phases: none, sender, receiver, both
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 60; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 60; end
            default: begin send_idle_pct = 28; rsp_stall_pct = 28; end
         endcase
         for (int c = 0; c < 2; c++) begin
            load_setting(p * 2 + c);
            test_random_traffic(215);
         end
      end

      test_output_backpressure();

      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && status_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
